@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers that report through $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts a property on the rising clock edge, disabled during reset.
`define FFHA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Asserts that a condition never holds on a rising clock edge.
`define FFHA_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ sv/ffha_pkg.sv @@
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int SPLIT_MIN    = 16;

  localparam int ADDR_W   = $clog2(HEAP_BYTES);
  localparam int END_W    = ADDR_W + 1;
  localparam int SIZE_W   = ADDR_W + 1;
  localparam int ENTRY_W  = SIZE_W + 1;
  localparam int PTR_W    = ADDR_W + 2;
  localparam int OP_W     = 2;
  localparam int BYTES_W  = 12;
  localparam int STATUS_W = 2;

  localparam logic [PTR_W-1:0] HDR_P   = PTR_W'(HEADER_BYTES);
  localparam logic [PTR_W-1:0] SPLIT_P = PTR_W'(SPLIT_MIN);
  localparam logic [PTR_W-1:0] HEAP_P  = PTR_W'(HEAP_BYTES);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHECK,
    S_A_DATA,
    S_A_SPLIT,
    S_F_CHECK,
    S_F_DATA,
    S_F_MERGE,
    S_F_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
  } ram_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] data_addr;
    status_t           status;
  } rslt_t;

  function automatic logic [ENTRY_W-1:0] mk_entry(input logic used,
                                                   input logic [SIZE_W-1:0] size);
    return {size, used};
  endfunction

endpackage

@@ sv/ffha_if.sv @@
// ---------------------------------------------------------------------------
// ffha request and response channels
// Valid/ready channels that carry allocator requests and their results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffha_req_if;
  import ffha_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [BYTES_W-1:0] req_bytes;
  logic [ADDR_W-1:0]  block_addr;

  modport source (output valid, output op, output req_bytes, output block_addr,
                  input ready);
  modport sink (input valid, input op, input req_bytes, input block_addr,
                output ready);
endinterface

interface ffha_rsp_if;
  import ffha_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   data_addr;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output data_addr, output status, input ready);
  modport sink (input valid, input data_addr, input status, output ready);
endinterface

@@ sv/ffha_hdr_ram.sv @@
// ---------------------------------------------------------------------------
// ffha_hdr_ram
// Single-clock memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffha_hdr_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ffha_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffha_ctrl
// Sequencer that walks block headers in the header memory and updates them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  ffha_req_if.sink                   req,
  input  logic [ffha_pkg::ENTRY_W-1:0] rdata,
  input  logic                       out_free,
  output ffha_pkg::ram_cmd_t         ram_cmd,
  output logic                       done,
  output ffha_pkg::rslt_t            result
);
  import ffha_pkg::*;

  state_t             state, state_next;
  logic [BYTES_W-1:0] req_q;
  logic [ADDR_W-1:0]  blk_q;
  logic [END_W-1:0]   heap_end, heap_end_next;
  logic [PTR_W-1:0]   aux, aux_next;
  logic [PTR_W-1:0]   prev_addr, prev_addr_next;
  logic               prev_used, prev_used_next;
  logic [SIZE_W-1:0]  prev_size, prev_size_next;
  logic               have_prev, have_prev_next;
  logic [PTR_W-1:0]   base, base_next;
  logic [PTR_W-1:0]   tsz, tsz_next;
  rslt_t              rslt, rslt_next;

  logic              accept;
  logic              rd_used;
  logic [SIZE_W-1:0] rd_size;
  logic [PTR_W-1:0]  rd_size_p;
  logic [PTR_W-1:0]  req_p;
  logic              aux_past;
  logic [PTR_W-1:0]  append_sum;
  logic              no_space;
  logic              fits;
  logic              split;
  logic [PTR_W-1:0]  walk_next;
  logic              match;
  logic [PTR_W-1:0]  next_hdr;
  logic              next_in;

  assign accept     = req.valid && req.ready;
  assign rd_used    = rdata[0];
  assign rd_size    = rdata[ENTRY_W-1:1];
  assign rd_size_p  = PTR_W'(rd_size);
  assign req_p      = PTR_W'(req_q);
  assign aux_past   = aux >= PTR_W'(heap_end);
  assign append_sum = PTR_W'(heap_end) + HDR_P + req_p;
  assign no_space   = append_sum > HEAP_P;
  assign fits       = !rd_used && (rd_size_p >= req_p);
  assign split      = rd_size_p > (req_p + HDR_P + SPLIT_P);
  assign walk_next  = aux + HDR_P + rd_size_p;
  assign match      = (aux + HDR_P) == PTR_W'(blk_q);
  assign next_hdr   = base + HDR_P + tsz;
  assign next_in    = next_hdr < PTR_W'(heap_end);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(req.op))
            OP_ALLOC: state_next = S_A_CHECK;
            OP_FREE: state_next = (heap_end == '0) ? S_DONE : S_F_CHECK;
            OP_RELEASE, OP_UNUSED: state_next = S_DONE;
          endcase
        end
      end
      S_A_CHECK: state_next = aux_past ? S_DONE : S_A_DATA;
      S_A_DATA: begin
        if (fits) begin
          state_next = split ? S_A_SPLIT : S_DONE;
        end else begin
          state_next = S_A_CHECK;
        end
      end
      S_A_SPLIT: state_next = S_DONE;
      S_F_CHECK: state_next = aux_past ? S_DONE : S_F_DATA;
      S_F_DATA: state_next = match ? S_F_MERGE : S_F_CHECK;
      S_F_MERGE: state_next = next_in ? S_F_NEXT : S_DONE;
      S_F_NEXT: state_next = S_DONE;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_cmd   = '0;
    req.ready = 1'b0;
    done      = 1'b0;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_A_CHECK: begin
        if (!aux_past) begin
          ram_cmd.re    = 1'b1;
          ram_cmd.raddr = aux[ADDR_W-1:0];
        end else if (!no_space) begin
          ram_cmd.we    = 1'b1;
          ram_cmd.waddr = heap_end[ADDR_W-1:0];
          ram_cmd.wdata = mk_entry(1'b1, SIZE_W'(req_q));
        end
      end
      S_A_DATA: begin
        if (fits) begin
          ram_cmd.we    = 1'b1;
          ram_cmd.waddr = aux[ADDR_W-1:0];
          ram_cmd.wdata = split ? mk_entry(1'b1, SIZE_W'(req_q)) : mk_entry(1'b1, rd_size);
        end
      end
      S_A_SPLIT: begin
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = base[ADDR_W-1:0];
        ram_cmd.wdata = mk_entry(1'b0, tsz[SIZE_W-1:0]);
      end
      S_F_CHECK: begin
        if (!aux_past) begin
          ram_cmd.re    = 1'b1;
          ram_cmd.raddr = aux[ADDR_W-1:0];
        end
      end
      S_F_MERGE: begin
        if (next_in) begin
          ram_cmd.re    = 1'b1;
          ram_cmd.raddr = next_hdr[ADDR_W-1:0];
        end else begin
          ram_cmd.we    = 1'b1;
          ram_cmd.waddr = base[ADDR_W-1:0];
          ram_cmd.wdata = mk_entry(1'b0, tsz[SIZE_W-1:0]);
        end
      end
      S_F_NEXT: begin
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = base[ADDR_W-1:0];
        ram_cmd.wdata = rd_used ? mk_entry(1'b0, tsz[SIZE_W-1:0])
                                : mk_entry(1'b0, SIZE_W'(tsz + HDR_P + rd_size_p));
      end
      S_DONE: done = out_free;
      default: ;
    endcase
  end

  always_comb begin
    heap_end_next  = heap_end;
    aux_next       = aux;
    prev_addr_next = prev_addr;
    prev_used_next = prev_used;
    prev_size_next = prev_size;
    have_prev_next = have_prev;
    base_next      = base;
    tsz_next       = tsz;
    rslt_next      = rslt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          aux_next       = '0;
          have_prev_next = 1'b0;
          rslt_next      = '{data_addr: '0, status: ST_OK};
          if (op_t'(req.op) == OP_FREE && heap_end == '0) begin
            rslt_next.status = ST_EMPTY;
          end
          if (op_t'(req.op) == OP_RELEASE) begin
            heap_end_next = '0;
          end
        end
      end
      S_A_CHECK: begin
        if (aux_past) begin
          if (no_space) begin
            rslt_next.status = ST_NO_SPACE;
          end else begin
            rslt_next.data_addr = heap_end[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
            heap_end_next       = append_sum[END_W-1:0];
          end
        end
      end
      S_A_DATA: begin
        if (fits) begin
          rslt_next.data_addr = ADDR_W'(aux + HDR_P);
          base_next           = aux + HDR_P + req_p;
          tsz_next            = rd_size_p - HDR_P - req_p;
        end else begin
          aux_next = walk_next;
        end
      end
      S_F_DATA: begin
        if (match) begin
          if (have_prev && !prev_used) begin
            base_next = prev_addr;
            tsz_next  = PTR_W'(prev_size) + HDR_P + rd_size_p;
          end else begin
            base_next = aux;
            tsz_next  = rd_size_p;
          end
        end else begin
          prev_addr_next = aux;
          prev_used_next = rd_used;
          prev_size_next = rd_size;
          have_prev_next = 1'b1;
          aux_next       = walk_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      heap_end <= '0;
    end else begin
      state    <= state_next;
      heap_end <= heap_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req.req_bytes;
      blk_q <= req.block_addr;
    end
    aux       <= aux_next;
    prev_addr <= prev_addr_next;
    prev_used <= prev_used_next;
    prev_size <= prev_size_next;
    have_prev <= have_prev_next;
    base      <= base_next;
    tsz       <= tsz_next;
    rslt      <= rslt_next;
  end

  assign result = rslt;

endmodule

@@ sv/first_fit_heap_allocator_unit.sv @@
// Each header walked takes one memory read and one check.
// An allocation ends on a fit, or takes a further step to write the split remainder or the appended header.
// A free walks to its block and merges; it also reads the next header to merge when it lies below the break.
// Free on an empty heap, release and unused ops go straight to the result.
// One item is in work at a time; a new item is taken once the result is in the output register.
// Reset clears the break and the control state; header memory is not cleared.
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over a header memory with an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_heap_allocator_unit (
  input logic        clk,
  input logic        rst,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);
  import ffha_pkg::*;

  ram_cmd_t           ram_cmd;
  logic [ENTRY_W-1:0] rdata;
  logic               done;
  rslt_t              result;
  logic               out_free;
  logic               rsp_valid;
  rslt_t              rsp_data;

  assign out_free = !rsp_valid || rsp.ready;

  ffha_hdr_ram #(
    .DEPTH(HEAP_BYTES),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .re   (ram_cmd.re),
    .raddr(ram_cmd.raddr),
    .rdata(rdata),
    .we   (ram_cmd.we),
    .waddr(ram_cmd.waddr),
    .wdata(ram_cmd.wdata)
  );

  ffha_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rdata   (rdata),
    .out_free(out_free),
    .ram_cmd (ram_cmd),
    .done    (done),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.data_addr = rsp_data.data_addr;
  assign rsp.status    = rsp_data.status;

  `FFHA_NEVER(a_no_rw_same_entry, clk, rst, ram_cmd.we && ram_cmd.re && (ram_cmd.waddr == ram_cmd.raddr), "Header read and write hit the same entry")
  `FFHA_NEVER(a_no_write_idle, clk, rst, ram_cmd.we && req.ready, "Header write while idle")
  `FFHA_ASSERT(a_one_item, clk, rst, (req.valid && req.ready) |=> !req.ready, "Second item taken while busy")
  `FFHA_ASSERT(a_fail_zero_addr, clk, rst, (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.data_addr == '0), "Failed request carries an address")

endmodule

@@ tb/sv/ffha_alloc_scoreboard.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heap allocator scoreboard
// Keeps its own copy of the block headers and the break, works out the
// expected grant for every accepted request and checks each result in order.
// ---------------------------------------------------------------------------

package ffha_alloc_tb_pkg;
  import ffha_pkg::*;

  class alloc_scoreboard;
    int unsigned hdr_word [HEAP_BYTES];
    int unsigned brk;
    rslt_t       pending_grants[$];
    int unsigned live_blocks[$];
    int unsigned retired_blocks[$];
    int unsigned last_grant;
    int          error_count;

    function new();
      brk         = 0;
      last_grant  = 0;
      error_count = 0;
    endfunction

    protected function int unsigned size_at(int unsigned pos);
      return hdr_word[pos % HEAP_BYTES] >> 1;
    endfunction

    protected function bit used_at(int unsigned pos);
      return hdr_word[pos % HEAP_BYTES][0];
    endfunction

    protected function void put_header(int unsigned pos, bit used, int unsigned size);
      hdr_word[pos % HEAP_BYTES] = (size << 1) | used;
    endfunction

    // First fit from offset zero; a new block goes at the break when nothing fits.
    protected function status_t place_block(int unsigned nbytes, output int unsigned addr);
      int unsigned pos, sz;
      addr = 0;
      pos  = 0;
      while (pos < brk) begin
        sz = size_at(pos);
        if (!used_at(pos) && sz >= nbytes) begin
          if (sz >= HEADER_BYTES + nbytes && sz - HEADER_BYTES - nbytes > SPLIT_MIN) begin
            put_header(pos, 1'b1, nbytes);
            put_header(pos + HEADER_BYTES + nbytes, 1'b0, sz - HEADER_BYTES - nbytes);
          end else begin
            put_header(pos, 1'b1, sz);
          end
          addr = pos + HEADER_BYTES;
          return ST_OK;
        end
        pos += HEADER_BYTES + sz;
      end
      if (brk + HEADER_BYTES + nbytes > HEAP_BYTES) return ST_NO_SPACE;
      put_header(brk, 1'b1, nbytes);
      addr = brk + HEADER_BYTES;
      brk += HEADER_BYTES + nbytes;
      return ST_OK;
    endfunction

    protected function status_t return_block(int unsigned baddr);
      int unsigned pos, prev, merged, nxt;
      bit          has_prev, hit;
      if (brk == 0) return ST_EMPTY;
      pos      = 0;
      prev     = 0;
      has_prev = 1'b0;
      hit      = 1'b0;
      while (pos < brk && !hit) begin
        if (pos + HEADER_BYTES == baddr) begin
          hit = 1'b1;
        end else begin
          prev     = pos;
          has_prev = 1'b1;
          pos     += HEADER_BYTES + size_at(pos);
        end
      end
      if (!hit) return ST_OK;
      merged = size_at(pos);
      if (has_prev && !used_at(prev)) begin
        merged = size_at(prev) + HEADER_BYTES + merged;
        pos    = prev;
      end
      nxt = pos + HEADER_BYTES + merged;
      if (nxt < brk && !used_at(nxt)) merged += HEADER_BYTES + size_at(nxt);
      put_header(pos, 1'b0, merged);
      return ST_OK;
    endfunction

    function void note_request(op_t op, int unsigned nbytes, int unsigned baddr);
      rslt_t       grant;
      int unsigned addr;
      int          idx[$];
      addr         = 0;
      grant.status = ST_OK;
      case (op)
        OP_ALLOC: begin
          grant.status = place_block(nbytes, addr);
          if (grant.status == ST_OK) begin
            last_grant = addr;
            if (addr < HEAP_BYTES) live_blocks.push_back(addr);
          end
        end
        OP_FREE: begin
          grant.status = return_block(baddr);
          idx = live_blocks.find_first_index(x) with (x == baddr);
          if (idx.size() != 0) live_blocks.delete(idx[0]);
          retired_blocks.push_back(baddr);
          if (retired_blocks.size() > 16) void'(retired_blocks.pop_front());
        end
        OP_RELEASE: begin
          brk = 0;
          live_blocks.delete();
        end
        default: begin
        end
      endcase
      grant.data_addr = addr[ADDR_W-1:0];
      pending_grants.push_back(grant);
    endfunction

    function void check_result(logic [ADDR_W-1:0] data_addr, logic [STATUS_W-1:0] status);
      rslt_t want;
      if (pending_grants.size() == 0) begin
        $error("result with no request outstanding: data_addr %0d, status %0d",
               data_addr, status);
        error_count++;
        return;
      end
      want = pending_grants.pop_front();
      if (data_addr !== want.data_addr) begin
        $error("data_addr: expected %0d, got %0d", want.data_addr, data_addr);
        error_count++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        error_count++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/first_fit_heap_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_unit testbench
// Drives allocate, free and release requests, first a directed sequence and
// then random traffic built mostly from real block addresses, under three
// idling patterns and one long output stall, and checks every result.
// ---------------------------------------------------------------------------

module first_fit_heap_allocator_unit_tb;
  import ffha_pkg::*;
  import ffha_alloc_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle_pct = 0;
  int   rcv_idle_pct = 0;
  bit   hold_request = 1'b0;
  int   cycle_count  = 0;
  alloc_scoreboard sb;

  ffha_req_if req_ch();
  ffha_rsp_if rsp_ch();

  first_fit_heap_allocator_unit i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  task automatic send_item(input op_t op, input logic [BYTES_W-1:0] nbytes,
                           input logic [ADDR_W-1:0] baddr);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.req_bytes  <= nbytes;
    req_ch.block_addr <= baddr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, nbytes, baddr);
  endtask

  // Mostly allocations and frees of live blocks; the rest is stale or
  // arbitrary addresses, releases, oversized requests and the unused op.
  task automatic run_phase(input int src_pct, input int rcv_pct, input int n_items);
    int                 done_items, roll, pick;
    logic [BYTES_W-1:0] nbytes;
    logic [ADDR_W-1:0]  baddr;
    op_t                op;
    bit                 counted;
    src_idle_pct = src_pct;
    rcv_idle_pct = rcv_pct;
    done_items   = 0;
    while (done_items < n_items) begin
      roll    = $urandom_range(999);
      nbytes  = BYTES_W'($urandom);
      baddr   = ADDR_W'($urandom);
      counted = 1'b1;
      if (roll < 560) begin
        op   = OP_ALLOC;
        pick = $urandom_range(99);
        if (pick < 2) nbytes = '0;
        else if (pick < 72) nbytes = BYTES_W'($urandom_range(256, 1));
        else if (pick < 94) nbytes = BYTES_W'($urandom_range(1024, 257));
        else nbytes = BYTES_W'($urandom_range(4080, 1025));
      end else if (roll < 960) begin
        op   = OP_FREE;
        pick = $urandom_range(99);
        if (pick < 85 && sb.live_blocks.size() != 0) begin
          baddr = ADDR_W'(sb.live_blocks[$urandom_range(sb.live_blocks.size() - 1)]);
        end else if (pick < 95 && sb.retired_blocks.size() != 0) begin
          baddr = ADDR_W'(sb.retired_blocks[$urandom_range(sb.retired_blocks.size() - 1)]);
        end else begin
          counted = 1'b0;
        end
      end else if (roll < 975) begin
        op = OP_RELEASE;
      end else if (roll < 985) begin
        op      = OP_UNUSED;
        counted = 1'b0;
      end else begin
        op     = OP_ALLOC;
        nbytes = BYTES_W'($urandom_range(4095, 2048));
      end
      send_item(op, nbytes, baddr);
      if (counted) done_items++;
    end
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(rsp_ch.data_addr, rsp_ch.status);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned a_lo, a_mid, a_hi, a_rem;
    sb = new();
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_RELEASE;
    req_ch.req_bytes  <= '0;
    req_ch.block_addr <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 20;
    rcv_idle_pct = 83;
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_FREE, '0, ADDR_W'(16));
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_ALLOC, BYTES_W'(1), '0);
    send_item(OP_ALLOC, '1, '0);
    send_item(OP_ALLOC, BYTES_W'(4080), '0);
    send_item(OP_ALLOC, BYTES_W'(100), '0);
    a_lo = sb.last_grant;
    send_item(OP_ALLOC, BYTES_W'(200), '0);
    a_mid = sb.last_grant;
    send_item(OP_ALLOC, BYTES_W'(300), '0);
    a_hi = sb.last_grant;
    send_item(OP_ALLOC, BYTES_W'(40), '0);
    send_item(OP_FREE, '0, ADDR_W'(a_mid));
    // Reusing the freed block splits it; the leftover is then taken whole.
    send_item(OP_ALLOC, BYTES_W'(50), '0);
    send_item(OP_ALLOC, BYTES_W'(120), '0);
    a_rem = sb.last_grant;
    send_item(OP_FREE, '0, ADDR_W'(a_mid));
    send_item(OP_FREE, '0, ADDR_W'(a_mid));
    send_item(OP_FREE, '0, ADDR_W'(a_rem));
    send_item(OP_FREE, '0, ADDR_W'(a_lo));
    send_item(OP_FREE, '0, ADDR_W'(a_hi));
    send_item(OP_FREE, '0, ADDR_W'(a_hi));
    send_item(OP_FREE, '0, '1);
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_ALLOC, BYTES_W'(4080), '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_RELEASE, '0, '0);

    run_phase(20, 83, RANDOM_ITEMS / 3);
    run_phase(83, 20, RANDOM_ITEMS / 3);
    hold_request = 1'b1;
    run_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    req_ch.valid <= 1'b0;

    while (sb.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
